/* rtl/unsigned_division_magic_number_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the magic number unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DIVISION_MAGIC_NUMBER_UNIT_MACROS_SVH
`define UNSIGNED_DIVISION_MAGIC_NUMBER_UNIT_MACROS_SVH

// same-cycle implication
`define UDM_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define UDM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/udm_pkg.sv */
// ----------------------------------------------------------------------------
// udm_pkg
// Shared widths, constants, sequencer states and divider interface types.
// ----------------------------------------------------------------------------
package udm_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned CntBits  = $clog2(WordBits);
  localparam int unsigned PBits    = 7;

  localparam logic [WordBits-1:0] HalfPow  = 32'h8000_0000;
  localparam logic [WordBits-1:0] HalfLess = 32'h7FFF_FFFF;
  localparam logic [PBits-1:0]    PStart   = 7'd31;
  localparam logic [PBits-1:0]    PLimit   = 7'd64;
  localparam logic [PBits-1:0]    PWord    = 7'd32;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NC_GO,
    S_NC_WAIT,
    S_Q1_GO,
    S_Q1_WAIT,
    S_Q2_GO,
    S_Q2_WAIT,
    S_ITER,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage

/* rtl/udm_div.sv */
// ----------------------------------------------------------------------------
// udm_div
// Restoring divider, one quotient bit per cycle, shared by all setup divisions.
// ----------------------------------------------------------------------------
module udm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  udm_pkg::div_req_t req_i,
  output udm_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = udm_pkg::WordBits;

  logic                          active_q, active_d;
  logic                          done_q, done_d;
  logic [udm_pkg::CntBits-1:0]   cnt_q, cnt_d;
  udm_pkg::word_t                quot_q, quot_d;
  udm_pkg::word_t                rem_q, rem_d;
  udm_pkg::word_t                den_q, den_d;
  logic [W:0]                    rem_shift;
  logic [W:0]                    rem_sub;
  logic                          fits;

  always_comb begin
    rem_shift = {rem_q, quot_q[W-1]};
    rem_sub   = rem_shift - {1'b0, den_q};
    fits      = rem_shift >= {1'b0, den_q};
  end

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    den_d    = den_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = '0;
      quot_d   = req_i.num;
      rem_d    = '0;
      den_d    = req_i.den;
    end else if (active_q) begin
      quot_d = {quot_q[W-2:0], fits};
      rem_d  = fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == udm_pkg::CntBits'(W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* rtl/unsigned_division_magic_number_unit.sv */
// ----------------------------------------------------------------------------
// unsigned_division_magic_number_unit
// Works out multiplier, add flag and post-shift for unsigned division by d.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------------
//  command   | start / busy     | divisor_i[31:0]
//  result    | done_o (strobe)  | multiplier_o[31:0], needs_add_o, shift_amount_o
//
//  An item runs three divisions in the shared bit-serial divider, then one
//  doubling step per cycle (1 to 33 steps) and a result state.
//  A zero divisor goes straight from idle to the result state.
//  busy rises in the cycle after acceptance and is low again in the cycle after done_o.
//  Results are shown for one cycle only; the receiver cannot stall.
//  Reset clears the sequencer and the divider control only.
// ----------------------------------------------------------------------------
`include "unsigned_division_magic_number_unit_macros.svh"

module unsigned_division_magic_number_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] multiplier_o,
  output logic        needs_add_o,
  output logic [5:0]  shift_amount_o
);

  localparam int unsigned W  = udm_pkg::WordBits;
  localparam int unsigned PW = udm_pkg::PBits;

  udm_pkg::state_e   state_q, state_d;
  udm_pkg::div_req_t div_req;
  udm_pkg::div_rsp_t div_rsp;

  udm_pkg::word_t    d_q, nc_q, q1_q, r1_q, q2_q, r2_q;
  udm_pkg::word_t    d_d, nc_d, q1_d, r1_d, q2_d, r2_d;
  logic [PW-1:0]     p_q, p_d;
  logic              a_q, a_d;

  // one doubling step
  logic [W:0]        r1x, r2x, r1_sub, r2_sub;
  logic              r1_ge, r2_ge, a_set, cont;
  udm_pkg::word_t    q1_n, r1_n, q2_n, r2_n, delta;
  logic [PW-1:0]     p_n;
  logic [PW-1:0]     shift_full;

  udm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    r1x    = {r1_q, 1'b0};
    r1_sub = r1x - {1'b0, nc_q};
    r1_ge  = r1x >= {1'b0, nc_q};
    r1_n   = r1_ge ? r1_sub[W-1:0] : r1x[W-1:0];
    q1_n   = {q1_q[W-2:0], r1_ge};

    r2x    = {r2_q, 1'b1};
    r2_sub = r2x - {1'b0, d_q};
    r2_ge  = r2x >= {1'b0, d_q};
    r2_n   = r2_ge ? r2_sub[W-1:0] : r2x[W-1:0];
    q2_n   = {q2_q[W-2:0], r2_ge};
    a_set  = r2_ge ? (q2_q >= udm_pkg::HalfLess) : q2_q[W-1];

    delta  = d_q - W'(1) - r2_n;
    p_n    = p_q + 1'b1;
    cont   = (p_n < udm_pkg::PLimit) &&
             ((q1_n < delta) || ((q1_n == delta) && (r1_n == '0)));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      udm_pkg::S_IDLE:    if (start) begin
                            state_d = (divisor_i == '0) ? udm_pkg::S_DONE : udm_pkg::S_NC_GO;
                          end
      udm_pkg::S_NC_GO:   state_d = udm_pkg::S_NC_WAIT;
      udm_pkg::S_NC_WAIT: if (div_rsp.done) state_d = udm_pkg::S_Q1_GO;
      udm_pkg::S_Q1_GO:   state_d = udm_pkg::S_Q1_WAIT;
      udm_pkg::S_Q1_WAIT: if (div_rsp.done) state_d = udm_pkg::S_Q2_GO;
      udm_pkg::S_Q2_GO:   state_d = udm_pkg::S_Q2_WAIT;
      udm_pkg::S_Q2_WAIT: if (div_rsp.done) state_d = udm_pkg::S_ITER;
      udm_pkg::S_ITER:    if (!cont) state_d = udm_pkg::S_DONE;
      udm_pkg::S_DONE:    state_d = udm_pkg::S_IDLE;
      default:            state_d = udm_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = udm_pkg::HalfLess;
    div_req.den   = d_q;
    d_d  = d_q;
    nc_d = nc_q;
    q1_d = q1_q;
    r1_d = r1_q;
    q2_d = q2_q;
    r2_d = r2_q;
    p_d  = p_q;
    a_d  = a_q;
    case (state_q)
      udm_pkg::S_IDLE: begin
        d_d = divisor_i;
        // zero divisor: all-ones q2 wraps to a zero multiplier, p of 32 gives no shift
        q2_d = '1;
        a_d  = 1'b0;
        p_d  = udm_pkg::PWord;
      end
      udm_pkg::S_NC_GO: begin
        div_req.start = 1'b1;
        div_req.num   = '0 - d_q;
        div_req.den   = d_q;
      end
      udm_pkg::S_NC_WAIT: begin
        if (div_rsp.done) nc_d = ~div_rsp.rem;
      end
      udm_pkg::S_Q1_GO: begin
        div_req.start = 1'b1;
        div_req.num   = udm_pkg::HalfPow;
        div_req.den   = nc_q;
      end
      udm_pkg::S_Q1_WAIT: begin
        if (div_rsp.done) begin
          q1_d = div_rsp.quot;
          r1_d = div_rsp.rem;
        end
      end
      udm_pkg::S_Q2_GO: begin
        div_req.start = 1'b1;
        div_req.num   = udm_pkg::HalfLess;
        div_req.den   = d_q;
      end
      udm_pkg::S_Q2_WAIT: begin
        if (div_rsp.done) begin
          q2_d = div_rsp.quot;
          r2_d = div_rsp.rem;
          p_d  = udm_pkg::PStart;
          a_d  = 1'b0;
        end
      end
      udm_pkg::S_ITER: begin
        q1_d = q1_n;
        r1_d = r1_n;
        q2_d = q2_n;
        r2_d = r2_n;
        p_d  = p_n;
        a_d  = a_q | a_set;
      end
      udm_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= udm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= d_d;
    nc_q <= nc_d;
    q1_q <= q1_d;
    r1_q <= r1_d;
    q2_q <= q2_d;
    r2_q <= r2_d;
    p_q  <= p_d;
    a_q  <= a_d;
  end

  assign shift_full     = p_q - udm_pkg::PWord;
  assign busy           = (state_q != udm_pkg::S_IDLE);
  assign done_o         = (state_q == udm_pkg::S_DONE);
  assign multiplier_o   = q2_q + W'(1);
  assign needs_add_o    = a_q;
  assign shift_amount_o = shift_full[5:0];

  `UDM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `UDM_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy, "result strobe longer than a cycle")
  `UDM_ASSERT_IMPL(a_shift_range, done_o, shift_amount_o <= 6'd32, "post-shift beyond 32")
  `UDM_ASSERT_IMPL(a_div_idle, div_rsp.done, state_q == udm_pkg::S_NC_WAIT ||
                   state_q == udm_pkg::S_Q1_WAIT || state_q == udm_pkg::S_Q2_WAIT,
                   "divider finished outside a wait state")

endmodule

/* test/udm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udm_checker
// Watches the command and result channels of the magic number unit. Each
// accepted divisor is turned into its expected multiplier, add flag and
// post-shift, and every done_o strobe is compared field by field with the
// oldest of those.
// ----------------------------------------------------------------------------
module udm_checker
  import udm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] divisor_i,
  input  logic        done_o,
  input  logic [31:0] multiplier_o,
  input  logic        needs_add_o,
  input  logic [5:0]  shift_amount_o,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    word_t      multiplier;
    logic       needs_add;
    logic [5:0] shift_amount;
  } magic_t;

  magic_t      expected_magic_q[$];
  int unsigned mismatch_count = 0;

  // Bit-exact magic constants for divisor d; zero yields all-zero fields.
  function automatic magic_t predict_magic(word_t d);
    word_t            neg_d, nc, q1, r1, q2, r2, delta;
    logic [PBits-1:0] p;
    logic             add_flag;
    magic_t           res;
    res = '0;
    if (d == '0) return res;
    add_flag = 1'b0;
    neg_d    = '0 - d;
    nc       = '1 - (neg_d % d);
    p        = PStart;
    q1       = HalfPow / nc;
    r1       = HalfPow - q1 * nc;
    q2       = HalfLess / d;
    r2       = HalfLess - q2 * d;
    do begin
      p = p + 1'b1;
      if (r1 >= nc - r1) begin
        q1 = {q1[30:0], 1'b1};
        r1 = (r1 << 1) - nc;
      end else begin
        q1 = q1 << 1;
        r1 = r1 << 1;
      end
      // a doubling that overflows 32 bits forces the add fixup
      if (r2 + 32'd1 >= d - r2) begin
        if (q2 >= HalfLess) add_flag = 1'b1;
        q2 = {q2[30:0], 1'b1};
        r2 = (r2 << 1) + 32'd1 - d;
      end else begin
        if (q2 >= HalfPow) add_flag = 1'b1;
        q2 = q2 << 1;
        r2 = (r2 << 1) + 32'd1;
      end
      delta = d - 32'd1 - r2;
    end while (p < PLimit && (q1 < delta || (q1 == delta && r1 == '0)));
    res.multiplier   = q2 + 32'd1;
    res.needs_add    = add_flag;
    res.shift_amount = 6'(p - PWord);
    return res;
  endfunction

  task automatic compare_field(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    magic_t want;
    if (rst_ni) begin
      if (start && !busy) expected_magic_q.push_back(predict_magic(divisor_i));
      if (done_o) begin
        if (expected_magic_q.size() == 0) begin
          $display("%0t: result with no item waiting, expected none, actual %h %b %0d",
                   $time, multiplier_o, needs_add_o, shift_amount_o);
          mismatch_count++;
        end else begin
          want = expected_magic_q.pop_front();
          compare_field("multiplier", want.multiplier, multiplier_o);
          compare_field("needs_add", want.needs_add, needs_add_o);
          compare_field("shift_amount", want.shift_amount, shift_amount_o);
        end
      end
    end
    mismatch_count_o <= mismatch_count;
    pending_count_o  <= expected_magic_q.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives divisors into the magic number unit: a directed set of edge values
// first, then random divisors over several sender idling phases. The checker
// predicts and compares; this module waits for the results to drain and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import udm_pkg::*;

  localparam int unsigned ItemsPerPhase = 475;
  localparam int unsigned DrainCycles   = 160;
  localparam int unsigned CycleLimit    = 1_500_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] divisor_i;
  logic        done_o;
  logic [31:0] multiplier_o;
  logic        needs_add_o;
  logic [5:0]  shift_amount_o;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  unsigned_division_magic_number_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .divisor_i      (divisor_i),
    .done_o         (done_o),
    .multiplier_o   (multiplier_o),
    .needs_add_o    (needs_add_o),
    .shift_amount_o (shift_amount_o)
  );

  udm_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .divisor_i        (divisor_i),
    .done_o           (done_o),
    .multiplier_o     (multiplier_o),
    .needs_add_o      (needs_add_o),
    .shift_amount_o   (shift_amount_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL unsigned_division_magic_number_unit");
      $finish;
    end
  end

  // Offer one item; start is redrawn every cycle so gaps land anywhere.
  task automatic send_divisor(input word_t d, input int unsigned idle_pct);
    logic offered;
    divisor_i <= d;
    offered = ($urandom_range(99) >= idle_pct);
    start <= offered;
    @(posedge clk_i);
    while (!(offered && !busy)) begin
      offered = ($urandom_range(99) >= idle_pct);
      start <= offered;
      @(posedge clk_i);
    end
  endtask

  function automatic word_t random_divisor();
    word_t d;
    case ($urandom_range(9))
      0, 1, 2, 3: d = $urandom;
      4, 5:       d = word_t'($urandom) >> $urandom_range(31);
      6:          d = $urandom_range(1000);
      7:          d = word_t'(1) << $urandom_range(31);
      8:          d = (word_t'(1) << $urandom_range(31)) + $urandom_range(2) - 1;
      default:    d = '1 - $urandom_range(1000);
    endcase
    return d;
  endfunction

  initial begin : stimulus
    word_t       edge_divisors[$];
    int unsigned idle_pct;
    edge_divisors = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10,
                      32'd100, 32'd125, 32'd641, 32'd65535, 32'd65536,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0001, 32'hC000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                      32'h0000_0007, 32'h0001_0001};
    start     <= 1'b0;
    divisor_i <= '0;
    rst_ni    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_divisors[i]) send_divisor(edge_divisors[i], 0);

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < ItemsPerPhase; n++) begin
        case (phase)
          0:       idle_pct = 0;
          1:       idle_pct = 74;
          2:       idle_pct = 6;
          default: idle_pct = ((n / 50) % 2) ? 74 : 0;
        endcase
        send_divisor(random_divisor(), idle_pct);
      end
    end
    start <= 1'b0;

    // pending count is registered in the checker, so it lags the checker's queue
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS unsigned_division_magic_number_unit");
    end else begin
      $display("FAIL unsigned_division_magic_number_unit");
    end
    $finish;
  end

endmodule
